@@ hdl/lagged_fibonacci_random_defines.svh @@
// ----------------------------------------------------------------------------
// Lagged Fibonacci random generator assertion macros
// Shared macros for the concurrent checks of the generator.
// ----------------------------------------------------------------------------
`ifndef LAGGED_FIBONACCI_RANDOM_DEFINES_SVH
`define LAGGED_FIBONACCI_RANDOM_DEFINES_SVH

// Checks a property on the rising clock edge while reset is released.
`define LFR_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Checks a property on the rising clock edge, reset included.
`define LFR_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hdl/lfr_pkg.sv @@
// ----------------------------------------------------------------------------
// Lagged Fibonacci random generator package
// Types, constants and helper functions shared by the generator modules.
// ----------------------------------------------------------------------------
package lfr_pkg;

    localparam int TABLE_LENGTH = 55;
    localparam int SHORT_START  = 31;
    localparam int LCG_WARMUP   = 2;
    localparam int WORD_W       = 32;

    localparam logic [WORD_W-1:0] LCG_MULT = 32'd17317;
    localparam logic [WORD_W-1:0] LCG_INC  = 32'd1;

    localparam logic FUNC_RESEED = 1'b0;
    localparam logic FUNC_DRAW   = 1'b1;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        logic load_seed;
        logic lcg_step;
        logic fill_write;
        logic draw_commit;
        logic restart;
    } lfr_cmd_t;

    typedef struct packed {
        logic out_busy;
    } lfr_status_t;

    function automatic word_t lcg_next(input word_t x);
        word_t product;
        product = x * LCG_MULT;
        return product + LCG_INC;
    endfunction

endpackage

@@ hdl/lfr_ram.sv @@
// ----------------------------------------------------------------------------
// Lagged Fibonacci random generator RAM
// Generic memory with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module lfr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 55,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr_a,
    output logic [WIDTH-1:0]  rdata_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [WIDTH-1:0]  rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

@@ hdl/lfr_control.sv @@
// ----------------------------------------------------------------------------
// Lagged Fibonacci random generator controller
// Sequences reseed and draw operations and issues datapath commands.
// ----------------------------------------------------------------------------
module lfr_control #(
    parameter int TABLE_LENGTH = lfr_pkg::TABLE_LENGTH,
    parameter int ADDR_W = $clog2(TABLE_LENGTH)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_func,
    input  lfr_pkg::lfr_status_t status,
    output lfr_pkg::lfr_cmd_t    cmd,
    output logic [ADDR_W-1:0]    fill_addr
);

    localparam logic [1:0] ST_IDLE     = 2'd0;
    localparam logic [1:0] ST_SCRAMBLE = 2'd1;
    localparam logic [1:0] ST_FILL     = 2'd2;
    localparam logic [1:0] ST_DRAW     = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_func == lfr_pkg::FUNC_DRAW) begin
                        state_next = ST_DRAW;
                    end else begin
                        cmd.load_seed = 1'b1;
                        cnt_next      = '0;
                        state_next    = ST_SCRAMBLE;
                    end
                end
            end
            ST_SCRAMBLE: begin
                cmd.lcg_step = 1'b1;
                if (cnt_reg == ADDR_W'(lfr_pkg::LCG_WARMUP - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_FILL;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FILL: begin
                cmd.lcg_step   = 1'b1;
                cmd.fill_write = 1'b1;
                if (cnt_reg == ADDR_W'(TABLE_LENGTH - 1)) begin
                    cmd.restart = 1'b1;
                    cnt_next    = '0;
                    state_next  = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DRAW: begin
                if (!status.out_busy) begin
                    cmd.draw_commit = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign fill_addr = cnt_reg;

endmodule

@@ hdl/lfr_datapath.sv @@
// ----------------------------------------------------------------------------
// Lagged Fibonacci random generator datapath
// LCG seed expansion, lag table, read positions and output register.
// ----------------------------------------------------------------------------
module lfr_datapath #(
    parameter int TABLE_LENGTH = lfr_pkg::TABLE_LENGTH,
    parameter int ADDR_W = $clog2(TABLE_LENGTH)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lfr_pkg::lfr_cmd_t    cmd,
    input  logic [ADDR_W-1:0]    fill_addr,
    output lfr_pkg::lfr_status_t status,
    input  logic [31:0]          s_seed_value,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [31:0]          m_random_fraction
);

    lfr_pkg::word_t    x_reg;
    lfr_pkg::word_t    x_step;
    lfr_pkg::word_t    rdata_a, rdata_b;
    lfr_pkg::word_t    diff;
    lfr_pkg::word_t    wdata;
    logic [ADDR_W-1:0] waddr;
    logic              we;
    logic [ADDR_W-1:0] long_pos_reg, long_pos_next;
    logic [ADDR_W-1:0] short_pos_reg, short_pos_next;
    logic              valid_reg [TABLE_LENGTH];
    logic              va_reg, vb_reg;
    logic              out_valid_reg;
    lfr_pkg::word_t    out_data_reg;

    assign x_step = lfr_pkg::lcg_next(x_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load_seed) begin
            x_reg <= s_seed_value;
        end else if (cmd.lcg_step) begin
            x_reg <= x_step;
        end
    end

    // Entries never written since reset read as zero.
    assign diff  = (va_reg ? rdata_a : '0) - (vb_reg ? rdata_b : '0);
    assign we    = cmd.fill_write | cmd.draw_commit;
    assign waddr = cmd.fill_write ? fill_addr : long_pos_reg;
    assign wdata = cmd.fill_write ? x_step : diff;

    lfr_ram #(
        .WIDTH (lfr_pkg::WORD_W),
        .DEPTH (TABLE_LENGTH)
    ) u_lfr_ram (
        .aclk    (aclk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (long_pos_reg),
        .rdata_a (rdata_a),
        .raddr_b (short_pos_reg),
        .rdata_b (rdata_b)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TABLE_LENGTH; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else if (we) begin
            valid_reg[waddr] <= 1'b1;
        end
        va_reg <= valid_reg[long_pos_reg];
        vb_reg <= valid_reg[short_pos_reg];
    end

    always_comb begin
        long_pos_next  = long_pos_reg;
        short_pos_next = short_pos_reg;
        if (cmd.restart) begin
            long_pos_next  = '0;
            short_pos_next = ADDR_W'(lfr_pkg::SHORT_START);
        end else if (cmd.draw_commit) begin
            long_pos_next  = (long_pos_reg == ADDR_W'(TABLE_LENGTH - 1)) ?
                             '0 : long_pos_reg + 1'b1;
            short_pos_next = (short_pos_reg == ADDR_W'(TABLE_LENGTH - 1)) ?
                             '0 : short_pos_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_pos_reg  <= '0;
            short_pos_reg <= ADDR_W'(lfr_pkg::SHORT_START);
            out_valid_reg <= 1'b0;
        end else begin
            long_pos_reg  <= long_pos_next;
            short_pos_reg <= short_pos_next;
            if (cmd.draw_commit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.draw_commit) begin
            out_data_reg <= diff;
        end
    end

    assign status.out_busy   = out_valid_reg & ~m_ready;
    assign m_valid           = out_valid_reg;
    assign m_random_fraction = out_data_reg;

endmodule

@@ hdl/lagged_fibonacci_random.sv @@
// ----------------------------------------------------------------------------
// Lagged Fibonacci random generator
// Subtractive lagged Fibonacci generator with lags 55 and 24 over UQ0.32 words.
// ----------------------------------------------------------------------------
// A draw beat (func = 1) returns table[long] - table[short] modulo 2^32 as an
// unsigned fraction of one, writes it back and advances both positions. It
// reads both lags from the table memory through its registered read ports,
// then subtracts and writes back. A reseed beat (func = 0) yields no result
// and is made up of the beat itself, two warm-up steps of the x*17317+1
// generator and 55 steps that fill the table one entry per cycle through
// its single write port. The result sits in an output register; a draw
// waits there only while an earlier result is still untaken. After reset
// the table reads as all zeros.
module lagged_fibonacci_random #(
    parameter int TABLE_LENGTH = lfr_pkg::TABLE_LENGTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [31:0] s_seed_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_random_fraction
);

    localparam int ADDR_W = $clog2(TABLE_LENGTH);

    lfr_pkg::lfr_cmd_t    cmd;
    lfr_pkg::lfr_status_t status;
    logic [ADDR_W-1:0]    fill_addr;

    lfr_control #(
        .TABLE_LENGTH (TABLE_LENGTH)
    ) u_lfr_control (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_func    (s_func),
        .status    (status),
        .cmd       (cmd),
        .fill_addr (fill_addr)
    );

    lfr_datapath #(
        .TABLE_LENGTH (TABLE_LENGTH)
    ) u_lfr_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .fill_addr         (fill_addr),
        .status            (status),
        .s_seed_value      (s_seed_value),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_random_fraction (m_random_fraction)
    );

endmodule

@@ hdl/lfr_checker.sv @@
// ----------------------------------------------------------------------------
// Lagged Fibonacci random generator checker
// Port-level checks of the generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "lagged_fibonacci_random_defines.svh"

module lfr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_func,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_random_fraction
);

    `LFR_ASSERT_RST(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_random_fraction), "result beat changed while stalled")

    `LFR_ASSERT_RST(a_reseed_busy, aclk, aresetn, s_valid && s_ready && s_func == lfr_pkg::FUNC_RESEED |=> !s_ready && !$rose(m_valid), "reseed beat not followed by busy phase")

    `LFR_ASSERT_RST(a_draw_result, aclk, aresetn, s_valid && s_ready && s_func == lfr_pkg::FUNC_DRAW && !m_valid |=> !s_ready ##1 m_valid && s_ready, "draw beat did not give a result")

    `LFR_ASSERT_ALWAYS(a_reset_state, aclk, !aresetn |=> s_ready && !m_valid, "block not idle after reset")

endmodule

bind lagged_fibonacci_random lfr_checker u_lfr_checker (.*);

@@ sim/lagged_fibonacci_checker.sv @@
// ----------------------------------------------------------------------------
// Lagged Fibonacci random generator checker
// Watches both channels of the generator and keeps its own copy of the lag
// table and read positions. Every accepted reseed beat reloads the table from
// the seed, and every accepted draw beat queues the expected fraction. Result
// beats are compared in order against that queue, and mismatches are counted.
// ----------------------------------------------------------------------------
module lagged_fibonacci_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_func,
    input  logic [31:0] s_seed_value,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_random_fraction,
    output int          error_count,
    output int          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    lfr_pkg::word_t lag_copy [lfr_pkg::TABLE_LENGTH];
    logic [5:0]     long_pos;
    logic [5:0]     short_pos;
    lfr_pkg::word_t expected_fractions [$];
    int             mismatches = 0;

    function automatic lfr_pkg::word_t scramble_word(input lfr_pkg::word_t x);
        return x * lfr_pkg::LCG_MULT + lfr_pkg::LCG_INC;
    endfunction

    function automatic logic [5:0] next_pos(input logic [5:0] p);
        return (p >= 6'(lfr_pkg::TABLE_LENGTH - 1)) ? 6'd0 : p + 6'd1;
    endfunction

    always @(posedge aclk) begin
        lfr_pkg::word_t x;
        lfr_pkg::word_t diff;
        lfr_pkg::word_t want;
        if (!aresetn) begin
            for (int i = 0; i < lfr_pkg::TABLE_LENGTH; i++) begin
                lag_copy[i] = '0;
            end
            long_pos  = '0;
            short_pos = 6'(lfr_pkg::SHORT_START);
            expected_fractions.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_fractions.size() == 0) begin
                    $display("%0t: random_fraction expected none, got %08h",
                             $time, m_random_fraction);
                    mismatches++;
                end else begin
                    want = expected_fractions.pop_front();
                    if (m_random_fraction !== want) begin
                        $display("%0t: random_fraction expected %08h, got %08h",
                                 $time, want, m_random_fraction);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_func == lfr_pkg::FUNC_RESEED) begin
                    x = s_seed_value;
                    for (int w = 0; w < lfr_pkg::LCG_WARMUP; w++) begin
                        x = scramble_word(x);
                    end
                    for (int i = 0; i < lfr_pkg::TABLE_LENGTH; i++) begin
                        x = scramble_word(x);
                        lag_copy[i] = x;
                    end
                    long_pos  = '0;
                    short_pos = 6'(lfr_pkg::SHORT_START);
                end else begin
                    diff = lag_copy[long_pos] - lag_copy[short_pos];
                    lag_copy[long_pos] = diff;
                    long_pos  = next_pos(long_pos);
                    short_pos = next_pos(short_pos);
                    expected_fractions.push_back(diff);
                end
            end
        end
        error_count   <= mismatches;
        pending_count <= expected_fractions.size();
    end

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// Lagged Fibonacci random generator testbench
// Drives reseed and draw beats into the generator in bursts with random
// gaps, while the result side stalls on its own pattern and once holds off
// long enough to back up the input. A directed opening covers draws from the
// zero table, extreme seeds and back-to-back reseeds; random sequences then
// reseed and draw past the table wrap. The checker gives the verdict count.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 750;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 100;

    typedef enum int {
        READY_ALWAYS,
        READY_HALF,
        READY_SPARSE,
        READY_TOGGLE,
        READY_HOLD
    } ready_mode_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid;
    logic        s_ready;
    logic        s_func;
    logic [31:0] s_seed_value;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_random_fraction;

    int error_count;
    int pending_count;
    int burst_left = 0;
    int items_sent = 0;
    int cycle_count = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    lagged_fibonacci_random dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_func            (s_func),
        .s_seed_value      (s_seed_value),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_random_fraction (m_random_fraction)
    );

    lagged_fibonacci_checker fraction_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_func            (s_func),
        .s_seed_value      (s_seed_value),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_random_fraction (m_random_fraction),
        .error_count       (error_count),
        .pending_count     (pending_count)
    );

    // Offers one beat, opening a new burst with an optional gap when the
    // current one is used up, and returns at the edge that accepts it.
    task automatic send_item(input logic func, input lfr_pkg::word_t seed);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 2) != 0) begin
                gap = $urandom_range(1, 8);
            end
        end
        burst_left--;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid      <= 1'b0;
            s_func       <= 1'($urandom_range(0, 1));
            s_seed_value <= $urandom;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_func       <= func;
        s_seed_value <= seed;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    function automatic lfr_pkg::word_t pick_seed();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    initial begin : stimulus
        int draws;
        s_valid      = 1'b0;
        s_func       = lfr_pkg::FUNC_RESEED;
        s_seed_value = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Draws from the all-zero table left by reset.
        send_item(lfr_pkg::FUNC_DRAW, 32'h0000_0000);
        send_item(lfr_pkg::FUNC_DRAW, 32'hFFFF_FFFF);
        send_item(lfr_pkg::FUNC_RESEED, 32'h0000_0000);
        repeat (3) send_item(lfr_pkg::FUNC_DRAW, $urandom);
        send_item(lfr_pkg::FUNC_RESEED, 32'hFFFF_FFFF);
        repeat (2) send_item(lfr_pkg::FUNC_DRAW, $urandom);
        send_item(lfr_pkg::FUNC_RESEED, 32'h8000_0000);
        send_item(lfr_pkg::FUNC_RESEED, 32'h0000_0001);
        repeat (2) send_item(lfr_pkg::FUNC_DRAW, 32'h0000_0000);
        send_item(lfr_pkg::FUNC_RESEED, 32'h7FFF_FFFF);
        send_item(lfr_pkg::FUNC_DRAW, 32'hFFFF_FFFF);
        send_item(lfr_pkg::FUNC_DRAW, 32'h5555_AAAA);

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            send_item(lfr_pkg::FUNC_RESEED, pick_seed());
            if ($urandom_range(0, 3) == 0) begin
                draws = $urandom_range(56, 170);
            end else begin
                draws = $urandom_range(1, 40);
            end
            repeat (draws) send_item(lfr_pkg::FUNC_DRAW, $urandom);
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        while (pending_count != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    initial begin : receiver
        ready_mode_t mode;
        int          seg_len;
        int          seen;
        bit          held;
        m_ready = 1'b0;
        seen    = 0;
        held    = 1'b0;
        @(posedge aresetn);
        forever begin
            mode    = ready_mode_t'($urandom_range(0, 3));
            seg_len = $urandom_range(8, 80);
            if (!held && seen > 1200) begin
                held    = 1'b1;
                mode    = READY_HOLD;
                seg_len = 400;
            end
            repeat (seg_len) begin
                @(negedge aclk);
                seen++;
                case (mode)
                    READY_ALWAYS: m_ready <= 1'b1;
                    READY_HALF:   m_ready <= 1'($urandom_range(0, 1));
                    READY_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                    READY_TOGGLE: m_ready <= ~m_ready;
                    default:      m_ready <= 1'b0;
                endcase
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/lfr_pkg.sv
hdl/lfr_ram.sv
hdl/lfr_control.sv
hdl/lfr_datapath.sv
hdl/lagged_fibonacci_random.sv
hdl/lfr_checker.sv
sim/lagged_fibonacci_checker.sv
sim/tb_top.sv
